// File: src/vid_pkg.sv
package vid_pkg;

	localparam int POSITION_DEPTH_DEF = 1024;
	localparam int TEXCOORD_DEPTH_DEF = 1024;
	localparam int NORMAL_DEPTH_DEF   = 1024;
	localparam int UNIQUE_DEPTH_DEF   = 1024;

	localparam int IDX_W  = 10;
	localparam int WORD_W = 32;

	// opcodes of an input item
	localparam logic [2:0] OP_LOAD_POS = 3'd0;
	localparam logic [2:0] OP_LOAD_TEX = 3'd1;
	localparam logic [2:0] OP_LOAD_NRM = 3'd2;
	localparam logic [2:0] OP_CORNER   = 3'd3;
	localparam logic [2:0] OP_CLEAR    = 3'd4;

	// result status codes
	localparam logic [1:0] ST_MATCH = 2'd0;
	localparam logic [1:0] ST_NEW   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [IDX_W-1:0]  entry_index;
		logic [WORD_W-1:0] word_x;
		logic [WORD_W-1:0] word_y;
		logic [WORD_W-1:0] word_z;
		logic [IDX_W-1:0]  position_index;
		logic [IDX_W-1:0]  texcoord_index;
		logic [IDX_W-1:0]  normal_index;
	} vid_in_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [IDX_W-1:0]  element_index;
		logic [WORD_W-1:0] pos_x;
		logic [WORD_W-1:0] pos_y;
		logic [WORD_W-1:0] pos_z;
		logic [WORD_W-1:0] tex_u;
		logic [WORD_W-1:0] tex_v;
		logic [WORD_W-1:0] nrm_x;
		logic [WORD_W-1:0] nrm_y;
		logic [WORD_W-1:0] nrm_z;
	} vid_out_t;

	typedef struct packed {
		logic       take;
		logic       clr_tbl;
		logic       ld_pos;
		logic       ld_tex;
		logic       ld_nrm;
		logic       scan_en;
		logic       set_res;
		logic [1:0] res_code;
		logic       append;
		logic       emit;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic       range_ok;
		logic       hit;
		logic       miss_done;
		logic       full;
		logic       out_free;
	} dp_sts_t;

	function automatic logic in_range(input logic [IDX_W-1:0] idx, input int depth);
		return {22'd0, idx} < 32'(depth);
	endfunction

endpackage

// File: src/vid_in_if.sv
interface vid_in_if
	import vid_pkg::*;
();

	logic              valid;
	logic              ready;
	logic [2:0]        opcode;
	logic [IDX_W-1:0]  entry_index;
	logic [WORD_W-1:0] word_x;
	logic [WORD_W-1:0] word_y;
	logic [WORD_W-1:0] word_z;
	logic [IDX_W-1:0]  position_index;
	logic [IDX_W-1:0]  texcoord_index;
	logic [IDX_W-1:0]  normal_index;

	modport source (
		output valid, opcode, entry_index, word_x, word_y, word_z,
		       position_index, texcoord_index, normal_index,
		input  ready
	);
	modport sink (
		input  valid, opcode, entry_index, word_x, word_y, word_z,
		       position_index, texcoord_index, normal_index,
		output ready
	);
endinterface

// File: src/vid_out_if.sv
interface vid_out_if
	import vid_pkg::*;
();

	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [IDX_W-1:0]  element_index;
	logic [WORD_W-1:0] pos_x;
	logic [WORD_W-1:0] pos_y;
	logic [WORD_W-1:0] pos_z;
	logic [WORD_W-1:0] tex_u;
	logic [WORD_W-1:0] tex_v;
	logic [WORD_W-1:0] nrm_x;
	logic [WORD_W-1:0] nrm_y;
	logic [WORD_W-1:0] nrm_z;

	modport source (
		output valid, status, element_index, pos_x, pos_y, pos_z,
		       tex_u, tex_v, nrm_x, nrm_y, nrm_z,
		input  ready
	);
	modport sink (
		input  valid, status, element_index, pos_x, pos_y, pos_z,
		       tex_u, tex_v, nrm_x, nrm_y, nrm_z,
		output ready
	);
endinterface

// File: src/vid_ram.sv
module vid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: src/vid_dp.sv
module vid_dp
	import vid_pkg::*;
#(
	parameter int POSITION_DEPTH = POSITION_DEPTH_DEF,
	parameter int TEXCOORD_DEPTH = TEXCOORD_DEPTH_DEF,
	parameter int NORMAL_DEPTH   = NORMAL_DEPTH_DEF,
	parameter int UNIQUE_DEPTH   = UNIQUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  vid_in_t  in_data,
	input  dp_cmd_t  cmd,
	output dp_sts_t  sts,
	output vid_out_t out_data,
	output logic     out_valid,
	input  logic     out_ready
);
	localparam int PAW = (POSITION_DEPTH > 1) ? $clog2(POSITION_DEPTH) : 1;
	localparam int TAW = (TEXCOORD_DEPTH > 1) ? $clog2(TEXCOORD_DEPTH) : 1;
	localparam int NAW = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
	localparam int UAW = (UNIQUE_DEPTH > 1) ? $clog2(UNIQUE_DEPTH) : 1;
	localparam int CW  = $clog2(UNIQUE_DEPTH + 1);
	localparam logic [CW-1:0] UNIQUE_MAX = CW'(UNIQUE_DEPTH);

	logic [IDX_W-1:0] pi_q, ti_q, ni_q;
	logic [CW-1:0]    count_q, scan_q, pidx_s1;
	logic             pend_s1;
	logic [1:0]       res_code_q;
	logic [IDX_W-1:0] res_elem_q;
	logic             out_valid_q;
	vid_out_t         out_q;

	logic [16:0] slot_ext, pi_ext, ti_ext, ni_ext, pidx_ext, count_ext;
	logic [95:0] pos_rdata, nrm_rdata;
	logic [63:0] tex_rdata;
	logic [29:0] trip_rdata;
	logic        scan_more, out_free;

	assign slot_ext  = {7'd0, in_data.entry_index};
	assign pi_ext    = {7'd0, pi_q};
	assign ti_ext    = {7'd0, ti_q};
	assign ni_ext    = {7'd0, ni_q};
	assign pidx_ext  = 17'(pidx_s1);
	assign count_ext = 17'(count_q);
	assign scan_more = scan_q < count_q;
	assign out_free  = !out_valid_q || out_ready;

	vid_ram #(.WIDTH(96), .DEPTH(POSITION_DEPTH)) u_pos_ram (
		.clk   (clk),
		.we    (cmd.ld_pos && in_range(in_data.entry_index, POSITION_DEPTH)),
		.waddr (slot_ext[PAW-1:0]),
		.wdata ({in_data.word_z, in_data.word_y, in_data.word_x}),
		.raddr (pi_ext[PAW-1:0]),
		.rdata (pos_rdata)
	);

	vid_ram #(.WIDTH(64), .DEPTH(TEXCOORD_DEPTH)) u_tex_ram (
		.clk   (clk),
		.we    (cmd.ld_tex && in_range(in_data.entry_index, TEXCOORD_DEPTH)),
		.waddr (slot_ext[TAW-1:0]),
		.wdata ({in_data.word_y, in_data.word_x}),
		.raddr (ti_ext[TAW-1:0]),
		.rdata (tex_rdata)
	);

	vid_ram #(.WIDTH(96), .DEPTH(NORMAL_DEPTH)) u_nrm_ram (
		.clk   (clk),
		.we    (cmd.ld_nrm && in_range(in_data.entry_index, NORMAL_DEPTH)),
		.waddr (slot_ext[NAW-1:0]),
		.wdata ({in_data.word_z, in_data.word_y, in_data.word_x}),
		.raddr (ni_ext[NAW-1:0]),
		.rdata (nrm_rdata)
	);

	vid_ram #(.WIDTH(30), .DEPTH(UNIQUE_DEPTH)) u_trip_ram (
		.clk   (clk),
		.we    (cmd.append),
		.waddr (count_q[UAW-1:0]),
		.wdata ({pi_q, ti_q, ni_q}),
		.raddr (scan_q[UAW-1:0]),
		.rdata (trip_rdata)
	);

	always_comb begin
		sts.opcode    = in_data.opcode;
		sts.range_ok  = in_range(pi_q, POSITION_DEPTH) && in_range(ti_q, TEXCOORD_DEPTH)
		                && in_range(ni_q, NORMAL_DEPTH);
		sts.hit       = pend_s1 && (trip_rdata == {pi_q, ti_q, ni_q});
		sts.miss_done = !pend_s1 && !scan_more;
		sts.full      = count_q >= UNIQUE_MAX;
		sts.out_free  = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pi_q <= in_data.position_index;
			ti_q <= in_data.texcoord_index;
			ni_q <= in_data.normal_index;
		end
		pidx_s1 <= scan_q;
		if (cmd.set_res) begin
			res_code_q <= cmd.res_code;
			case (cmd.res_code)
				ST_MATCH: res_elem_q <= pidx_ext[IDX_W-1:0];
				ST_NEW:   res_elem_q <= count_ext[IDX_W-1:0];
				default:  res_elem_q <= '0;
			endcase
		end
		if (cmd.emit) begin
			out_q.status        <= res_code_q;
			out_q.element_index <= res_elem_q;
			if (res_code_q == ST_NEW) begin
				{out_q.pos_z, out_q.pos_y, out_q.pos_x} <= pos_rdata;
				{out_q.tex_v, out_q.tex_u}              <= tex_rdata;
				{out_q.nrm_z, out_q.nrm_y, out_q.nrm_x} <= nrm_rdata;
			end else begin
				{out_q.pos_z, out_q.pos_y, out_q.pos_x} <= '0;
				{out_q.tex_v, out_q.tex_u}              <= '0;
				{out_q.nrm_z, out_q.nrm_y, out_q.nrm_x} <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_tbl) begin
				count_q <= '0;
			end else if (cmd.append) begin
				count_q <= count_q + 1'b1;
			end
			// one triple read issued a cycle while scan_en is set and entries remain, compared the cycle after
			if (cmd.take) begin
				scan_q  <= '0;
				pend_s1 <= 1'b0;
			end else begin
				pend_s1 <= cmd.scan_en && scan_more;
				if (cmd.scan_en && scan_more) begin
					scan_q <= scan_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= UNIQUE_MAX)
		else $error("unique count past table depth");

	a_append_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |=> count_q == $past(count_q) + 1'b1)
		else $error("append did not advance count");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> count_q < UNIQUE_MAX)
		else $error("append into a full table");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result register overwritten");

	a_hit_live: assert property (@(posedge clk) disable iff (!arst_n)
		sts.hit |-> pidx_s1 < count_q)
		else $error("match on an entry beyond the table");
endmodule

// File: src/vid_ctrl.sv
module vid_ctrl
	import vid_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_CHECK  = 2'd1;
	localparam logic [1:0] S_SEARCH = 2'd2;
	localparam logic [1:0] S_EMIT   = 2'd3;

	logic [1:0] state_q, state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (sts.opcode)
						OP_LOAD_POS: cmd.ld_pos = 1'b1;
						OP_LOAD_TEX: cmd.ld_tex = 1'b1;
						OP_LOAD_NRM: cmd.ld_nrm = 1'b1;
						OP_CLEAR:    cmd.clr_tbl = 1'b1;
						OP_CORNER: begin
							cmd.take  = 1'b1;
							state_nxt = S_CHECK;
						end
						default: ;
					endcase
				end
			end
			// store reads for the new indices are issued during this cycle
			S_CHECK: begin
				if (!sts.range_ok) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_RANGE;
					state_nxt    = S_EMIT;
				end else begin
					state_nxt = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.scan_en = 1'b1;
				if (sts.hit) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_MATCH;
					state_nxt    = S_EMIT;
				end else if (sts.miss_done) begin
					cmd.set_res = 1'b1;
					if (sts.full) begin
						cmd.res_code = ST_FULL;
					end else begin
						cmd.res_code = ST_NEW;
						cmd.append   = 1'b1;
					end
					state_nxt = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> state_q == S_CHECK)
		else $error("corner transfer did not start a check");

	a_append_miss: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> state_q == S_SEARCH && sts.miss_done && !sts.hit)
		else $error("append outside a completed miss");

	a_emit_ret: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> in_ready)
		else $error("controller not idle after result");
endmodule

// File: src/vertex_index_dedup.sv
// Load and clear transfers: one cycle each, next transfer accepted the cycle after.
// Face corner: the indices are range-checked; if in range the unique table is scanned
// until a hit on table entry k or a miss on every entry; the result (match, new entry,
// full table or index out of range) loads the result register. The next transfer is
// taken the cycle after the result register loads; a held result stalls that load.
// arst_n clears the controller, unique count and output valid; stores are not cleared.
module vertex_index_dedup
	import vid_pkg::*;
#(
	parameter int POSITION_DEPTH = POSITION_DEPTH_DEF,
	parameter int TEXCOORD_DEPTH = TEXCOORD_DEPTH_DEF,
	parameter int NORMAL_DEPTH   = NORMAL_DEPTH_DEF,
	parameter int UNIQUE_DEPTH   = UNIQUE_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	vid_in_if.sink     req,
	vid_out_if.source  rsp
);
	vid_in_t  in_data;
	vid_out_t out_data;
	dp_cmd_t  cmd;
	dp_sts_t  sts;
	logic     out_valid;

	assign in_data.opcode         = req.opcode;
	assign in_data.entry_index    = req.entry_index;
	assign in_data.word_x         = req.word_x;
	assign in_data.word_y         = req.word_y;
	assign in_data.word_z         = req.word_z;
	assign in_data.position_index = req.position_index;
	assign in_data.texcoord_index = req.texcoord_index;
	assign in_data.normal_index   = req.normal_index;

	vid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vid_dp #(
		.POSITION_DEPTH (POSITION_DEPTH),
		.TEXCOORD_DEPTH (TEXCOORD_DEPTH),
		.NORMAL_DEPTH   (NORMAL_DEPTH),
		.UNIQUE_DEPTH   (UNIQUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (rsp.ready)
	);

	assign rsp.valid         = out_valid;
	assign rsp.status        = out_data.status;
	assign rsp.element_index = out_data.element_index;
	assign rsp.pos_x         = out_data.pos_x;
	assign rsp.pos_y         = out_data.pos_y;
	assign rsp.pos_z         = out_data.pos_z;
	assign rsp.tex_u         = out_data.tex_u;
	assign rsp.tex_v         = out_data.tex_v;
	assign rsp.nrm_x         = out_data.nrm_x;
	assign rsp.nrm_y         = out_data.nrm_y;
	assign rsp.nrm_z         = out_data.nrm_z;
endmodule
